// ===== sv/bdil_pkg.sv =====
package bdil_pkg;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [7:0]        FG_VALUE      = 8'd255;
   localparam logic [SIZE_W-1:0] MIN_SIZE      = 13'd3;
   localparam logic [SIZE_W-1:0] COORD_LIMIT   = 13'd4096;
   localparam logic [SIZE_W-1:0] RESET_WIDTH   = 13'd640;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT  = 13'd480;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               out_black;
      logic               run_last;
   } rsp_payload_type;

   // frame size after clamping
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               fg;
      logic               has_int;
      logic               has_bord;
   } front_stage_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               fg;
      logic               up1;
      logic               up2;
      logic               has_int;
      logic               has_bord;
   } mid_entry_type;

   // one entry holds the interior result and/or the border result of one item
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               black;
      logic               has_int;
      logic               has_bord;
   } res_entry_type;

endpackage

// ===== sv/bdil_fifo.sv =====
module bdil_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [0:DEPTH-1];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      count_in = count_ff + CW'(push_ok) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/bdil_front.sv =====
module bdil_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bdil_pkg::geom_type       geom,
   input  logic                     req_push,
   input  bdil_pkg::req_payload_type req_data,
   output logic                     req_full,
   output logic                     mid_push,
   output bdil_pkg::mid_entry_type  mid_data,
   input  logic                     mid_full
);

   import bdil_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // entry bit 1: row before last, bit 0: previous row
   logic [1:0] line_mem [0:MAX_WIDTH-1];

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   front_stage_type    s1_ff, s1_in;
   logic [1:0]         rd_ff;
   logic               fwd_ff;
   logic [1:0]         fwd_data_ff;

   logic               accept, move;
   logic [COORD_W-1:0] col0, row0, x, y;
   logic               wrap_col;
   logic [SIZE_W-1:0]  row1, x_inc, y_inc;
   logic [1:0]         up;
   logic [AW+COORD_W-1:0] raddr_ext, waddr_ext;
   logic [AW-1:0]      raddr, waddr;

   assign move     = s1_valid_ff && !mid_full;
   assign req_full = s1_valid_ff && mid_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      col0     = req_data.frame_start ? '0 : col_ff;
      row0     = req_data.frame_start ? '0 : row_ff;
      wrap_col = ({1'b0, col0} >= geom.width);
      row1     = wrap_col ? {1'b0, row0} + SIZE_W'(1) : {1'b0, row0};
      x        = wrap_col ? '0 : col0;
      y        = (row1 >= geom.height) ? '0 : row1[COORD_W-1:0];
      x_inc    = {1'b0, x} + SIZE_W'(1);
      y_inc    = {1'b0, y} + SIZE_W'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (x_inc >= geom.width) begin
            col_in = '0;
            row_in = (y_inc >= geom.height) ? '0 : y_inc[COORD_W-1:0];
         end else begin
            col_in = x_inc[COORD_W-1:0];
            row_in = y;
         end
      end

      s1_in.x        = x;
      s1_in.y        = y;
      s1_in.fg       = (req_data.pixel_value == FG_VALUE);
      s1_in.has_int  = (x >= COORD_W'(2)) && (y >= COORD_W'(2));
      s1_in.has_bord = (x == '0) || ({1'b0, x} == geom.width - SIZE_W'(1))
                       || (y == '0) || ({1'b0, y} == geom.height - SIZE_W'(1));

      s1_valid_in = accept || (s1_valid_ff && !move);

      raddr_ext = {{AW{1'b0}}, x};
      waddr_ext = {{AW{1'b0}}, s1_ff.x};
      raddr     = raddr_ext[AW-1:0];
      waddr     = waddr_ext[AW-1:0];
   end

   // a write in the same cycle as the read of that column is bypassed
   assign up = fwd_ff ? fwd_data_ff : rd_ff;

   always_comb begin
      mid_push          = move;
      mid_data.x        = s1_ff.x;
      mid_data.y        = s1_ff.y;
      mid_data.fg       = s1_ff.fg;
      mid_data.up1      = up[0];
      mid_data.up2      = up[1];
      mid_data.has_int  = s1_ff.has_int;
      mid_data.has_bord = s1_ff.has_bord;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            fwd_ff <= move && (s1_ff.x == x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         rd_ff       <= line_mem[raddr];
         fwd_data_ff <= {up[0], s1_ff.fg};
      end
      if (move) begin
         line_mem[waddr] <= {up[0], s1_ff.fg};
      end
   end

endmodule

// ===== sv/bdil_back.sv =====
module bdil_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mid_empty,
   input  bdil_pkg::mid_entry_type   mid_data,
   output logic                      mid_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output bdil_pkg::rsp_payload_type rsp_data
);

   import bdil_pkg::*;

   localparam int RES_DEPTH = 4;

   logic [8:0]    window_ff, window_in;
   logic          phase_ff, phase_in;
   res_entry_type res_wr, res_head;
   logic          res_push, res_full, res_pop, res_empty;
   logic          first_int, last;

   bdil_fifo #(
      .WIDTH ($bits(res_entry_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (res_pop),
      .pop_data  (res_head),
      .empty     (res_empty)
   );

   always_comb begin
      mid_pop   = !mid_empty && !res_full;
      window_in = {window_ff[5:0], mid_data.up2, mid_data.up1, mid_data.fg};

      res_wr.x        = mid_data.x;
      res_wr.y        = mid_data.y;
      res_wr.black    = |window_in;
      res_wr.has_int  = mid_data.has_int;
      res_wr.has_bord = mid_data.has_bord;
      res_push        = mid_pop && (mid_data.has_int || mid_data.has_bord);
   end

   // an entry with both results gives the interior one first, then the border
   always_comb begin
      first_int = !phase_ff && res_head.has_int;
      last      = phase_ff || !(res_head.has_int && res_head.has_bord);

      rsp_empty          = res_empty;
      rsp_data.out_x     = first_int ? res_head.x - COORD_W'(1) : res_head.x;
      rsp_data.out_y     = first_int ? res_head.y - COORD_W'(1) : res_head.y;
      rsp_data.out_black = first_int && res_head.black;
      rsp_data.run_last  = last;

      res_pop  = rsp_pop && !res_empty && last;
      phase_in = phase_ff;
      if (rsp_pop && !res_empty) begin
         phase_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         phase_ff  <= 1'b0;
      end else begin
         if (mid_pop) begin
            window_ff <= window_in;
         end
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== sv/binary_dilation_3x3_stream_top.sv =====
// An item goes through the stage register, the front/back queue and result queue.
// One item per cycle unless a full queue stalls; results leave at one per cycle,
// so an item with an interior and a border result holds the output for two pops.
// Reset (synchronous): clears position, window and queues; size reverts to 640x480.
// The line stores are not cleared; the first two rows of a frame fill them.
module binary_dilation_3x3_stream_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  bdil_pkg::req_payload_type req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output bdil_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [12:0]               csr_wdata
);

   import bdil_pkg::*;

   localparam int MID_DEPTH = 4;
   localparam logic [SIZE_W-1:0] WIDTH_HI =
      (MAX_WIDTH < 4096) ? SIZE_W'(MAX_WIDTH) : COORD_LIMIT;
   localparam logic [SIZE_W-1:0] RESET_W_USED =
      (RESET_WIDTH > WIDTH_HI) ? WIDTH_HI : RESET_WIDTH;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] width_clamp, height_clamp;
   geom_type          geom;
   logic              mid_push, mid_full, mid_pop, mid_empty;
   mid_entry_type     mid_wr, mid_rd;

   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_wdata < MIN_SIZE) begin
         width_clamp = MIN_SIZE;
      end else if (csr_wdata > WIDTH_HI) begin
         width_clamp = WIDTH_HI;
      end else begin
         width_clamp = csr_wdata;
      end
      if (csr_wdata < MIN_SIZE) begin
         height_clamp = MIN_SIZE;
      end else if (csr_wdata > COORD_LIMIT) begin
         height_clamp = COORD_LIMIT;
      end else begin
         height_clamp = csr_wdata;
      end
      geom.width  = width_ff;
      geom.height = height_ff;
   end

   // sizes are kept already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_W_USED;
         height_ff <= RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_ff <= width_clamp;
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= height_clamp;
            end
            default: begin
            end
         endcase
      end
   end

   bdil_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .mid_push (mid_push),
      .mid_data (mid_wr),
      .mid_full (mid_full)
   );

   bdil_fifo #(
      .WIDTH ($bits(mid_entry_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rd),
      .empty     (mid_empty)
   );

   bdil_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(mid_push && mid_full))
      else $error("item pushed into full front/back queue");

   a_mid_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(mid_pop && mid_empty))
      else $error("item taken from empty front/back queue");

   a_pair_second_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_data.run_last) |=> !rsp_empty)
      else $error("second result of an item missing");

   a_pair_second_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_data.run_last) |=>
      (!rsp_data.out_black && rsp_data.run_last))
      else $error("second result of an item is not a white border result");
`endif

endmodule

// ===== tb/binary_dilation_3x3_stream_top_tb.sv =====
`timescale 1ns / 1ps

module binary_dilation_3x3_stream_top_tb;
   import bdil_pkg::*;

   localparam int IDLE_PCT      = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int LINE_DEPTH    = 4096;
   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_PIXELS = 150;
   localparam int WIDE_PIXELS   = 40;
   localparam int TALL_PIXELS   = 60;
   // index with no register behind it; writes there are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_push  = 1'b0;
   req_payload_type          req_data  = '0;
   logic                     req_full;
   logic                     rsp_empty;
   logic                     rsp_pop   = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [SIZE_W-1:0]        csr_wdata = '0;

   // predictor state
   logic [SIZE_W-1:0] width_reg  = RESET_WIDTH;
   logic [SIZE_W-1:0] height_reg = RESET_HEIGHT;
   bit                above_row[LINE_DEPTH];
   bit                two_up_row[LINE_DEPTH];
   logic [8:0]        window_mask = '0;
   int unsigned       col_pos = 0;
   int unsigned       row_pos = 0;
   rsp_payload_type   due_pixels[$];

   int errors          = 0;
   int pixels_sent     = 0;
   int results_checked = 0;
   bit no_gaps         = 1'b0;

   binary_dilation_3x3_stream_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic int unsigned bounded_size(input logic [SIZE_W-1:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > COORD_LIMIT) return COORD_LIMIT;
      return v;
   endfunction

   function automatic logic [7:0] random_pixel();
      if ($urandom_range(99) < 30) return FG_VALUE;
      return 8'($urandom_range(0, 254));
   endfunction

   // works out the results one accepted pixel causes and queues them
   task automatic dilate_pixel(input req_payload_type it);
      int unsigned     w;
      int unsigned     h;
      int unsigned     x;
      int unsigned     y;
      logic            fg;
      logic            up1;
      logic            up2;
      int              n;
      rsp_payload_type res[2];
      w = bounded_size(width_reg);
      h = bounded_size(height_reg);
      if (it.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      fg = (it.pixel_value == FG_VALUE);
      up1 = above_row[x];
      up2 = two_up_row[x];
      two_up_row[x] = up1;
      above_row[x] = fg;
      window_mask = {window_mask[5:0], up2, up1, fg};
      n = 0;
      if (x >= 2 && y >= 2) begin
         res[n] = '0;
         res[n].out_x = COORD_W'(x - 1);
         res[n].out_y = COORD_W'(y - 1);
         res[n].out_black = (window_mask != 0);
         n++;
      end
      if (x == 0 || x == w - 1 || y == 0 || y == h - 1) begin
         res[n] = '0;
         res[n].out_x = COORD_W'(x);
         res[n].out_y = COORD_W'(y);
         n++;
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) due_pixels.push_back(res[i]);
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x & 12'hFFF;
      row_pos = y & 12'hFFF;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_checked++;
         if (due_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with none expected: x=%0d y=%0d black=%0b last=%0b",
                        $time, rsp_data.out_x, rsp_data.out_y, rsp_data.out_black,
                        rsp_data.run_last);
         end else begin
            want = due_pixels[0];
            due_pixels.delete(0);
            if (rsp_data.out_x !== want.out_x) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: out_x expected %0d actual %0d", $time, want.out_x,
                           rsp_data.out_x);
            end
            if (rsp_data.out_y !== want.out_y) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: out_y expected %0d actual %0d", $time, want.out_y,
                           rsp_data.out_y);
            end
            if (rsp_data.out_black !== want.out_black) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: out_black at (%0d,%0d) expected %0b actual %0b", $time,
                           want.out_x, want.out_y, want.out_black, rsp_data.out_black);
            end
            if (rsp_data.run_last !== want.run_last) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: run_last at (%0d,%0d) expected %0b actual %0b", $time,
                           want.out_x, want.out_y, want.run_last, rsp_data.run_last);
            end
         end
      end
   end

   task automatic send_pixel(input logic [7:0] pix, input logic start);
      req_payload_type it;
      it.pixel_value = pix;
      it.frame_start = start;
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full !== 1'b0);
      dilate_pixel(it);
      pixels_sent++;
   endtask

   task automatic send_frame(input int count, input logic start_first);
      for (int i = 0; i < count; i++) send_pixel(random_pixel(), start_first && i == 0);
   endtask

   // hold off until every queued result is out and the pipe has gone quiet
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_FRAME_WIDTH) width_reg = val;
      else if (idx == CSR_FRAME_HEIGHT) height_reg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_size();
      send_pixel(8'd0, 1'b1);
      send_pixel(FG_VALUE, 1'b0);
      send_pixel(8'h5A, 1'b0);
      settle();
   endtask

   task automatic test_small_frame();
      // sizes below the minimum clamp to 3x3
      write_csr(CSR_FRAME_WIDTH, 13'd1);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      send_pixel(8'd254, 1'b1);
      for (int i = 0; i < 8; i++) send_pixel(8'd0, 1'b0);
      // second frame follows without a start flag; foreground only in the far corner
      for (int i = 0; i < 9; i++) send_pixel(i == 8 ? FG_VALUE : 8'd0, 1'b0);
      send_pixel(FG_VALUE, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(FG_VALUE, 1'b1);
      send_pixel(8'd0, 1'b0);
      settle();
   endtask

   task automatic test_mid_frame_resize();
      write_csr(CSR_FRAME_WIDTH, 13'd6);
      write_csr(CSR_FRAME_HEIGHT, 13'd6);
      send_frame(23, 1'b1);
      settle();
      // column 5 of row 3 lies past the new width: wraps to row 4, which is past the new height, so to row 0
      write_csr(CSR_FRAME_WIDTH, 13'd4);
      write_csr(CSR_FRAME_HEIGHT, 13'd4);
      write_csr(CSR_SPARE, 13'($urandom));
      send_frame(8, 1'b0);
      settle();
   endtask

   task automatic test_largest_sizes();
      write_csr(CSR_FRAME_WIDTH, 13'h1FFF);
      write_csr(CSR_FRAME_HEIGHT, 13'd3);
      send_frame(WIDE_PIXELS, 1'b1);
      settle();
      write_csr(CSR_FRAME_WIDTH, 13'd0);
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      no_gaps = 1'b1;
      send_frame(TALL_PIXELS, 1'b1);
      no_gaps = 1'b0;
      settle();
   endtask

   task automatic test_random_frames();
      int                r;
      int                area;
      int                len;
      int                sent;
      logic [SIZE_W-1:0] w_set;
      logic [SIZE_W-1:0] h_set;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         r = $urandom_range(99);
         if (r < 8) w_set = 13'($urandom_range(0, 2));
         else if (r < 20) w_set = 13'($urandom_range(13, 40));
         else w_set = 13'($urandom_range(3, 12));
         h_set = ($urandom_range(99) < 8) ? 13'($urandom_range(0, 2))
                                          : 13'($urandom_range(3, 10));
         write_csr(CSR_FRAME_WIDTH, w_set);
         write_csr(CSR_FRAME_HEIGHT, h_set);
         area = bounded_size(w_set) * bounded_size(h_set);
         r = $urandom_range(99);
         if (r < 20) len = $urandom_range(1, area);
         else if (r < 40) len = 2 * area + $urandom_range(0, 5);
         else len = area;
         if (len > RANDOM_PIXELS - sent) len = RANDOM_PIXELS - sent;
         for (int i = 0; i < len; i++)
            send_pixel(random_pixel(), i == 0 || $urandom_range(99) < 3);
         sent += len;
         settle();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_size();
      test_small_frame();
      test_mid_frame_resize();
      test_largest_sizes();
      test_random_frames();
      settle();
      $display("sent %0d pixels, checked %0d results; sizes from 3x3 up to the 4096 clamp",
               pixels_sent, results_checked);
      $display("included clamped sizes, frame overrun, restarts mid-frame and a mid-frame resize");
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timed out with %0d results outstanding", due_pixels.size());
      $display("status: fail");
      $finish;
   end

endmodule
